[src/ota_pkg.sv]
// ----------------------------------------------------------------------------
// ota_pkg: shared types and constants for the over-temperature alarm monitor
// Field widths, register indexes, reset values, alarm modes and sequencer
// states used by the top level and the serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

package ota_pkg;

  // Field widths
  localparam int TEMP_W      = 8;
  localparam int TIME_W      = 32;
  localparam int HOLD_W      = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int REG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 16;

  // Default sample bound per window
  localparam int MAX_SAMPLES_DEF = 1024;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_TEMP_LIMIT     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DETECT_HOLD    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_AVERAGE_WINDOW = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_RESTORE_HOLD   = 2'd3;

  // Reset values
  localparam logic signed [TEMP_W-1:0] TEMP_LIMIT_RST     = 8'sd40;
  localparam logic [HOLD_W-1:0]        DETECT_HOLD_RST    = 16'd6000;
  localparam logic [HOLD_W-1:0]        AVERAGE_WINDOW_RST = 16'd1000;
  localparam logic [HOLD_W-1:0]        RESTORE_HOLD_RST   = 16'd2000;
  localparam logic signed [TEMP_W-1:0] AVERAGE_TEMP_RST   = 8'sd20;

  // Alarm modes
  typedef enum logic [1:0] {
    MODE_NORMAL    = 2'd0,
    MODE_SUSPECT   = 2'd1,
    MODE_CONFIRMED = 2'd2
  } mode_t;

  // Event pulses of one result, wake in the lowest bit
  typedef struct packed {
    logic restore_ev;
    logic sleep_problem_ev;
    logic problem_ev;
    logic wake_ev;
  } events_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_DIVIDE,
    ST_MODE,
    ST_PUSH
  } seq_state_t;

endpackage

`default_nettype wire

[src/ota_divider.sv]
// ----------------------------------------------------------------------------
// ota_divider: serial signed-by-unsigned divider
// Restoring shift/subtract unit, one quotient bit per cycle. Quotient is
// truncated toward zero; the low TEMP_W bits are returned.
// ----------------------------------------------------------------------------
`default_nettype none

module ota_divider #(
  parameter int MAG_W = 18,
  parameter int CNT_W = 11
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic signed [MAG_W:0]           dividend,
  input  wire logic [CNT_W-1:0]                divisor,
  output logic                                 done,
  output logic signed [ota_pkg::TEMP_W-1:0]    quotient
);

  localparam int STEP_W = $clog2(MAG_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic              neg;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvs;
  logic [MAG_W-1:0]  quo;
  logic [MAG_W:0]    mag_full;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    diff;
  logic              fits;
  logic [MAG_W-1:0]  quo_signed;

  // Magnitude of the dividend
  assign mag_full = dividend[MAG_W] ? (~dividend + 1'b1) : dividend;

  // One restoring step
  assign shifted = {rem, quo[MAG_W-1]};
  assign fits    = shifted >= {1'b0, dvs};
  assign diff    = shifted - {1'b0, dvs};

  assign done       = busy && (steps == '0);
  assign quo_signed = neg ? (~quo + 1'b1) : quo;
  assign quotient   = quo_signed[ota_pkg::TEMP_W-1:0];

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= STEP_W'(MAG_W);
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy) begin
      steps <= steps - 1'b1;
    end
  end

  // Operands and partial results
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[MAG_W];
      quo <= mag_full[MAG_W-1:0];
      rem <= '0;
      dvs <= divisor;
    end else if (busy && (steps != '0)) begin
      rem <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      quo <= {quo[MAG_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

[src/overtemp_alarm_monitor.sv]
// One item at a time, through the accumulate, divide (only when a window closes with
// samples), mode and push steps; the serial divider gives one quotient bit per cycle.
// The next input is taken once the result is in the output register, so a stalled
// output holds back the next input. Synchronous active-high reset sets the alarm
// state, window and configuration to their reset values.
// ----------------------------------------------------------------------------
// overtemp_alarm_monitor: windowed temperature average with a three-mode alarm
// Sums and counts samples per window, divides on a window close with samples in a
// serial divider, then steps the normal/suspect/confirmed alarm sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module overtemp_alarm_monitor #(
  parameter int MAX_SAMPLES = ota_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration write port
  input  wire logic                                cfg_we,
  input  wire logic [ota_pkg::REG_IDX_W-1:0]       cfg_addr,
  input  wire logic [ota_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // input stream
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // now_ms[31:0], sample_temp[39:32], restore_pending[40], system_asleep[41],
  // restore_cmd[42], zero fill [47:43]
  input  wire logic [ota_pkg::IN_TDATA_W-1:0]      s_tdata,
  // result stream
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // mode[1:0], held_temp[9:2], wake_event[10], problem_event[11],
  // sleep_problem_event[12], restore_event[13], zero fill [15:14]
  output logic [ota_pkg::OUT_TDATA_W-1:0]          m_tdata
);

  localparam int TEMP_W = ota_pkg::TEMP_W;
  localparam int TIME_W = ota_pkg::TIME_W;
  localparam int HOLD_W = ota_pkg::HOLD_W;
  localparam int MAG_W  = $clog2((2 ** (TEMP_W - 1)) * MAX_SAMPLES + 1);
  localparam int SUM_W  = MAG_W + 1;
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);
  localparam int EV_LSB = 2 + TEMP_W;

  // Configuration registers
  logic signed [TEMP_W-1:0] temp_limit;
  logic [HOLD_W-1:0]        detect_hold_ms;
  logic [HOLD_W-1:0]        average_window_ms;
  logic [HOLD_W-1:0]        restore_hold_ms;

  // Block state
  ota_pkg::seq_state_t      state, state_next;
  ota_pkg::mode_t           mode_reg, mode_next;
  logic [TIME_W-1:0]        mode_entry_time;
  logic [TIME_W-1:0]        window_start;
  logic signed [SUM_W-1:0]  temp_sum;
  logic [CNT_W-1:0]         sample_count;
  logic signed [TEMP_W-1:0] average_temp;

  // Latched input item
  logic [TIME_W-1:0]        now_l;
  logic [TEMP_W-1:0]        sample_l;
  logic                     pending_l;
  logic                     asleep_l;
  logic                     cmd_l;

  // Result events waiting for the output register
  ota_pkg::events_t         ev_hold, ev_next;

  logic                     in_xfer;
  logic                     below_max;
  logic signed [SUM_W-1:0]  sum_acc;
  logic [CNT_W-1:0]         cnt_acc;
  logic [TIME_W-1:0]        win_elapsed;
  logic                     win_close;
  logic [TIME_W-1:0]        mode_elapsed;
  logic                     entry_set;
  logic                     div_start;
  logic                     div_done;
  logic signed [TEMP_W-1:0] div_quot;
  logic                     out_load;

  assign in_xfer = s_tvalid && s_tready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_limit        <= ota_pkg::TEMP_LIMIT_RST;
      detect_hold_ms    <= ota_pkg::DETECT_HOLD_RST;
      average_window_ms <= ota_pkg::AVERAGE_WINDOW_RST;
      restore_hold_ms   <= ota_pkg::RESTORE_HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ota_pkg::REG_TEMP_LIMIT:     temp_limit        <= cfg_wdata[TEMP_W-1:0];
        ota_pkg::REG_DETECT_HOLD:    detect_hold_ms    <= cfg_wdata[HOLD_W-1:0];
        ota_pkg::REG_AVERAGE_WINDOW: average_window_ms <= cfg_wdata[HOLD_W-1:0];
        ota_pkg::REG_RESTORE_HOLD:   restore_hold_ms   <= cfg_wdata[HOLD_W-1:0];
      endcase
    end
  end

  // Capture the input item
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      now_l     <= s_tdata[TIME_W-1:0];
      sample_l  <= s_tdata[TIME_W+TEMP_W-1:TIME_W];
      pending_l <= s_tdata[TIME_W+TEMP_W];
      asleep_l  <= s_tdata[TIME_W+TEMP_W+1];
      cmd_l     <= s_tdata[TIME_W+TEMP_W+2];
    end
  end

  // Accumulate and window test
  assign below_max   = sample_count < MAX_CNT;
  assign sum_acc     = below_max ?
                       temp_sum + {{(SUM_W-TEMP_W){sample_l[TEMP_W-1]}}, sample_l} :
                       temp_sum;
  assign cnt_acc     = below_max ? sample_count + 1'b1 : sample_count;
  assign win_elapsed = now_l - window_start;
  assign win_close   = win_elapsed > {{(TIME_W-HOLD_W){1'b0}}, average_window_ms};

  // Serial divider
  ota_divider #(
    .MAG_W (MAG_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_acc),
    .divisor  (cnt_acc),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Alarm mode transition
  assign mode_elapsed = now_l - mode_entry_time;

  always_comb begin
    mode_next = mode_reg;
    entry_set = 1'b0;
    ev_next   = '0;
    unique case (mode_reg)
      ota_pkg::MODE_SUSPECT: begin
        if (average_temp < temp_limit) begin
          mode_next = ota_pkg::MODE_NORMAL;
          entry_set = 1'b1;
        end else if (mode_elapsed > {{(TIME_W-HOLD_W){1'b0}}, detect_hold_ms}) begin
          mode_next = ota_pkg::MODE_CONFIRMED;
          entry_set = 1'b1;
          if (asleep_l) begin
            ev_next.sleep_problem_ev = 1'b1;
          end else begin
            ev_next.problem_ev = 1'b1;
          end
        end
      end
      ota_pkg::MODE_CONFIRMED: begin
        if (cmd_l && !asleep_l) begin
          mode_next          = ota_pkg::MODE_NORMAL;
          entry_set          = 1'b1;
          ev_next.restore_ev = 1'b1;
        end
      end
      default: begin
        // normal; entering suspect resets the timer, and no wake is raised on that tick
        mode_next = ota_pkg::MODE_NORMAL;
        if (average_temp > temp_limit) begin
          mode_next = ota_pkg::MODE_SUSPECT;
          entry_set = 1'b1;
        end else if (pending_l &&
                     (mode_elapsed > {{(TIME_W-HOLD_W){1'b0}}, restore_hold_ms})) begin
          entry_set       = 1'b1;
          ev_next.wake_ev = 1'b1;
        end
      end
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ota_pkg::ST_IDLE:   if (in_xfer) state_next = ota_pkg::ST_ACCUM;
      ota_pkg::ST_ACCUM:  state_next = div_start ? ota_pkg::ST_DIVIDE : ota_pkg::ST_MODE;
      ota_pkg::ST_DIVIDE: if (div_done) state_next = ota_pkg::ST_MODE;
      ota_pkg::ST_MODE:   state_next = ota_pkg::ST_PUSH;
      ota_pkg::ST_PUSH:   if (out_load) state_next = ota_pkg::ST_IDLE;
      default:            state_next = ota_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_tready  = (state == ota_pkg::ST_IDLE);
    div_start = (state == ota_pkg::ST_ACCUM) && win_close && (cnt_acc != '0);
    out_load  = (state == ota_pkg::ST_PUSH) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ota_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Window, average and alarm state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg        <= ota_pkg::MODE_NORMAL;
      mode_entry_time <= '0;
      window_start    <= '0;
      temp_sum        <= '0;
      sample_count    <= '0;
      average_temp    <= ota_pkg::AVERAGE_TEMP_RST;
    end else begin
      if (state == ota_pkg::ST_ACCUM) begin
        if (win_close) begin
          temp_sum     <= '0;
          sample_count <= '0;
          window_start <= now_l;
        end else begin
          temp_sum     <= sum_acc;
          sample_count <= cnt_acc;
        end
      end
      if ((state == ota_pkg::ST_DIVIDE) && div_done) begin
        average_temp <= div_quot;
      end
      if (state == ota_pkg::ST_MODE) begin
        mode_reg <= mode_next;
        if (entry_set) begin
          mode_entry_time <= now_l;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ota_pkg::ST_MODE) begin
      ev_hold <= ev_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {2'b00, ev_hold, average_temp, mode_reg};
    end
  end

  // Checks
  a_one_event: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($countones(m_tdata[EV_LSB+3:EV_LSB]) <= 1))
    else $error("more than one event pulse in a result");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    sample_count <= MAX_CNT)
    else $error("sample count beyond bound");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ota_pkg::ST_DIVIDE))
    else $error("divider finished outside the divide step");

  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state == ota_pkg::ST_ACCUM))
    else $error("transfer not followed by accumulate step");

  a_window_clear: assert property (@(posedge clk) disable iff (rst)
    ((state == ota_pkg::ST_ACCUM) && win_close) |=> (sample_count == '0))
    else $error("window close did not clear the count");

endmodule

`default_nettype wire

[tb/overtemp_alarm_monitor_test.sv]
// ----------------------------------------------------------------------------
// overtemp_alarm_monitor_test: self-checking bench for the over-temperature alarm
// Directed ticks walk the alarm through every mode change, the window edges and
// the 32-bit time wrap. Random phases follow, each under its own register
// setting and handshake idling: short windows with drifting temperatures, the lowest
// register values, the highest with one long window of dense ticks, random settings.
// A built-in predictor of the averaging and mode logic supplies each expected
// result, and every output transfer is checked against it in order.
// ----------------------------------------------------------------------------
`default_nettype none

module overtemp_alarm_monitor_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          TEMP_W         = ota_pkg::TEMP_W;
  localparam int          TIME_W         = ota_pkg::TIME_W;
  localparam int          HOLD_W         = ota_pkg::HOLD_W;
  localparam int          REG_IDX_W      = ota_pkg::REG_IDX_W;
  localparam int          CFG_DATA_W     = ota_pkg::CFG_DATA_W;
  localparam int          IN_TDATA_W     = ota_pkg::IN_TDATA_W;
  localparam int          OUT_TDATA_W    = ota_pkg::OUT_TDATA_W;
  localparam int          MAX_SAMPLES    = ota_pkg::MAX_SAMPLES_DEF;
  localparam int          SETTLE_CYCLES  = 40;
  localparam int unsigned TIMEOUT_CYCLES = 400000;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          MAX_REPORTS    = 10;

  // One tick as offered on the input stream
  typedef struct {
    logic [TIME_W-1:0]        now;
    logic signed [TEMP_W-1:0] temp;
    logic                     pend;
    logic                     asleep;
    logic                     cmd;
  } tick_t;

  // One alarm result as seen on the output stream
  typedef struct {
    ota_pkg::mode_t           mode;
    logic signed [TEMP_W-1:0] held;
    ota_pkg::events_t         ev;
  } alarm_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [REG_IDX_W-1:0]   cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b1;
  logic [OUT_TDATA_W-1:0] m_tdata;

  overtemp_alarm_monitor #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Predictor copy of registers and state
  logic signed [TEMP_W-1:0] cfg_limit;
  logic [HOLD_W-1:0]        cfg_detect_hold;
  logic [HOLD_W-1:0]        cfg_window;
  logic [HOLD_W-1:0]        cfg_restore_hold;
  ota_pkg::mode_t           alarm_mode;
  logic [TIME_W-1:0]        mode_since;
  logic [TIME_W-1:0]        win_start;
  int                       acc_sum;
  int                       acc_count;
  logic signed [TEMP_W-1:0] held_avg;

  tick_t         tick_q[$];
  alarm_result_t alarm_q[$];
  tick_t         shown_tick;
  bit            in_taken;

  int          send_idle_pct;
  int          stall_pct;
  int          hold_gen;
  int          hold_seen;
  int          hold_left;
  int          err_count;
  logic [31:0] t_clock;
  int          temp_level;

  initial begin
    forever #10 clk = ~clk;
  end

  // Advance the predicted state by one tick and return the expected result
  function automatic alarm_result_t advance_alarm(tick_t t);
    alarm_result_t r;
    r.ev = '0;
    if (acc_count < MAX_SAMPLES) begin
      acc_sum += int'(t.temp);
      acc_count++;
    end
    if (32'(t.now - win_start) > 32'(cfg_window)) begin
      if (acc_count != 0) held_avg = TEMP_W'(acc_sum / acc_count);
      acc_sum = 0;
      acc_count = 0;
      win_start = t.now;
    end
    case (alarm_mode)
      ota_pkg::MODE_SUSPECT: begin
        if (int'(held_avg) < int'(cfg_limit)) begin
          alarm_mode = ota_pkg::MODE_NORMAL;
          mode_since = t.now;
        end else if (32'(t.now - mode_since) > 32'(cfg_detect_hold)) begin
          alarm_mode = ota_pkg::MODE_CONFIRMED;
          mode_since = t.now;
          if (t.asleep) r.ev.sleep_problem_ev = 1'b1;
          else r.ev.problem_ev = 1'b1;
        end
      end
      ota_pkg::MODE_CONFIRMED: begin
        if (t.cmd && !t.asleep) begin
          r.ev.restore_ev = 1'b1;
          alarm_mode = ota_pkg::MODE_NORMAL;
          mode_since = t.now;
        end
      end
      default: begin
        alarm_mode = ota_pkg::MODE_NORMAL;
        if (int'(held_avg) > int'(cfg_limit)) begin
          alarm_mode = ota_pkg::MODE_SUSPECT;
          mode_since = t.now;
        end
        if (32'(t.now - mode_since) > 32'(cfg_restore_hold) && t.pend) begin
          r.ev.wake_ev = 1'b1;
          alarm_mode = ota_pkg::MODE_NORMAL;
          mode_since = t.now;
        end
      end
    endcase
    r.mode = alarm_mode;
    r.held = held_avg;
    return r;
  endfunction

  // Input side: offer the next pending tick at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        shown_tick = tick_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, shown_tick.cmd, shown_tick.asleep, shown_tick.pend,
                    shown_tick.temp, shown_tick.now};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    in_taken = 1'b0;
  end

  // Input transfer: predict the result it must produce
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      alarm_q.push_back(advance_alarm(shown_tick));
      in_taken = 1'b1;
    end
  end

  // Output side: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_seen != hold_gen) begin
      hold_seen = hold_gen;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Output transfer: compare with the oldest expectation
  always @(posedge clk) begin
    alarm_result_t got;
    alarm_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.mode = ota_pkg::mode_t'(m_tdata[1:0]);
      got.held = m_tdata[9:2];
      got.ev   = m_tdata[13:10];
      if (alarm_q.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("%0t: unexpected result mode=%0d held=%0d events=%b",
                   $realtime, got.mode, got.held, got.ev);
      end else begin
        want = alarm_q.pop_front();
        if (got.mode !== want.mode || got.held !== want.held || got.ev !== want.ev) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: result mismatch: mode %0d/%0d held %0d/%0d events %b/%b (exp/act)",
                     $realtime, want.mode, got.mode, want.held, got.held, want.ev, got.ev);
        end
      end
    end
  end

  task automatic push_tick(logic [31:0] now, int temp, bit pend, bit asleep, bit cmd);
    tick_t t;
    t.now = now;
    t.temp = TEMP_W'(temp);
    t.pend = pend;
    t.asleep = asleep;
    t.cmd = cmd;
    tick_q.push_back(t);
  endtask

  // Rising time with a temperature drifting around the limit; a few noise ticks jump to a random time and temperature
  task automatic add_ticks(int n, int unsigned step_max);
    tick_t t;
    int    v;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 8)
        temp_level = int'(cfg_limit) + int'($urandom_range(24)) - 12;
      if ($urandom_range(99) < 5) begin
        t_clock = $urandom();
        t.temp = TEMP_W'($urandom());
      end else begin
        t_clock += $urandom_range(step_max);
        v = temp_level + int'($urandom_range(6)) - 3;
        if (v > 127) v = 127;
        if (v < -128) v = -128;
        t.temp = TEMP_W'(v);
      end
      t.now = t_clock;
      t.pend = ($urandom_range(99) < 30);
      t.asleep = ($urandom_range(99) < 30);
      t.cmd = ($urandom_range(99) < 25);
      tick_q.push_back(t);
    end
  endtask

  // Register write; only issued while nothing is in flight
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      ota_pkg::REG_TEMP_LIMIT:     cfg_limit = val[TEMP_W-1:0];
      ota_pkg::REG_DETECT_HOLD:    cfg_detect_hold = val;
      ota_pkg::REG_AVERAGE_WINDOW: cfg_window = val;
      default:                     cfg_restore_hold = val;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (tick_q.size() != 0 || s_tvalid || alarm_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Watchdog
  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Stimulus sequence
  initial begin
    tick_t t;
    cfg_limit        = ota_pkg::TEMP_LIMIT_RST;
    cfg_detect_hold  = ota_pkg::DETECT_HOLD_RST;
    cfg_window       = ota_pkg::AVERAGE_WINDOW_RST;
    cfg_restore_hold = ota_pkg::RESTORE_HOLD_RST;
    alarm_mode       = ota_pkg::MODE_NORMAL;
    mode_since       = '0;
    win_start        = '0;
    acc_sum          = 0;
    acc_count        = 0;
    held_avg         = ota_pkg::AVERAGE_TEMP_RST;
    send_idle_pct    = 0;
    stall_pct        = 0;
    hold_gen         = 0;
    hold_seen        = 0;
    hold_left        = 0;
    err_count        = 0;
    in_taken         = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset registers, mode walk, window edges, time wrap
    push_tick(5, 127, 0, 0, 0);
    push_tick(10, -128, 1, 1, 1);
    push_tick(1001, 127, 1, 0, 0);        // enters suspect, no wake on entry tick
    push_tick(7002, 40, 0, 0, 0);         // average at limit, hold expired: problem
    push_tick(7003, 0, 0, 1, 1);          // restore while asleep is ignored
    push_tick(7004, 0, 0, 0, 1);          // restore
    push_tick(7005, 0, 1, 0, 0);
    push_tick(9005, 0, 1, 0, 0);          // restore hold passed: wake
    push_tick(9006, 100, 0, 0, 0);
    push_tick(10007, 100, 0, 0, 0);
    push_tick(16008, 100, 0, 1, 0);       // confirmed while asleep
    push_tick(16009, 50, 0, 0, 1);
    push_tick(17010, 50, 0, 0, 0);
    push_tick(18011, -128, 0, 0, 0);      // average below limit: back to normal
    push_tick(19011, 0, 0, 0, 0);         // elapsed equals window, stays open
    push_tick(19012, 0, 0, 0, 0);
    push_tick(32'hFFFF_FFF0, 0, 0, 0, 0);
    push_tick(32'h0000_0400, 0, 0, 0, 0); // elapsed across the wrap
    push_tick(32'h0000_0800, 40, 0, 0, 0); // average equal to limit in normal
    t_clock = 32'h0000_0800;
    drain();

    // Short windows, no idling, long output hold-off at the start
    write_reg(ota_pkg::REG_TEMP_LIMIT, 16'h000A);
    write_reg(ota_pkg::REG_DETECT_HOLD, 16'd200);
    write_reg(ota_pkg::REG_AVERAGE_WINDOW, 16'd40);
    write_reg(ota_pkg::REG_RESTORE_HOLD, 16'd100);
    temp_level = int'(cfg_limit);
    hold_gen++;
    add_ticks(120, 30);
    drain();

    // Lowest register values, sender mostly idle
    write_reg(ota_pkg::REG_TEMP_LIMIT, 16'hFF80);
    write_reg(ota_pkg::REG_DETECT_HOLD, 16'd0);
    write_reg(ota_pkg::REG_AVERAGE_WINDOW, 16'd0);
    write_reg(ota_pkg::REG_RESTORE_HOLD, 16'd0);
    temp_level = int'(cfg_limit);
    send_idle_pct = 81;
    add_ticks(100, 3);
    drain();

    // Highest register values, receiver mostly stalled; one long window of dense ticks
    write_reg(ota_pkg::REG_TEMP_LIMIT, 16'h007F);
    write_reg(ota_pkg::REG_DETECT_HOLD, 16'hFFFF);
    write_reg(ota_pkg::REG_AVERAGE_WINDOW, 16'hFFFF);
    write_reg(ota_pkg::REG_RESTORE_HOLD, 16'hFFFF);
    send_idle_pct = 0;
    stall_pct = 81;
    t_clock += 70000;
    for (int i = 0; i < 540; i++) begin
      t.now = t_clock;
      t.temp = TEMP_W'($urandom());
      t.pend = ($urandom_range(1) == 1);
      t.asleep = ($urandom_range(1) == 1);
      t.cmd = ($urandom_range(1) == 1);
      tick_q.push_back(t);
      t_clock += $urandom_range(1);
    end
    t_clock += 70000;
    push_tick(t_clock, 0, 0, 0, 0);       // closes the long window
    drain();

    // Random settings, both sides idling
    write_reg(ota_pkg::REG_TEMP_LIMIT, CFG_DATA_W'($urandom()));
    write_reg(ota_pkg::REG_DETECT_HOLD, CFG_DATA_W'($urandom_range(300)));
    write_reg(ota_pkg::REG_AVERAGE_WINDOW, CFG_DATA_W'($urandom_range(60)));
    write_reg(ota_pkg::REG_RESTORE_HOLD, CFG_DATA_W'($urandom_range(200)));
    temp_level = int'(cfg_limit);
    send_idle_pct = 26;
    stall_pct = 26;
    add_ticks(170, 40);
    drain();

    if (err_count == 0 && alarm_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

[overtemp_alarm_monitor.f]
src/ota_pkg.sv
src/ota_divider.sv
src/overtemp_alarm_monitor.sv
tb/overtemp_alarm_monitor_test.sv
